// ----- rtl/core/spa_pkg.sv -----
// Package of the slot pool allocator: sizes, codes and sequencer states.
`default_nettype none

package spa_pkg;

    // Default pool size and the width of one word of the used map.
    localparam int SPA_SLOTS = 256;
    localparam int WORD_W    = 16;
    localparam int BIT_W     = 4;

    // Command codes of an input transfer.
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/spa_if.sv -----
// Channel interfaces of the slot pool allocator: command channel and result channel.
`default_nettype none

interface spa_cmd_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] slot;

    modport source (output valid, output command, output slot, input ready);
    modport sink   (input valid, input command, input slot, output ready);
endinterface

interface spa_res_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [7:0]        granted_slot;
    logic [8:0]        used_count;
    logic signed [8:0] highest_used;
    logic [8:0]        lowest_free;

    modport source (output valid, output status, output granted_slot, output used_count,
                    output highest_used, output lowest_free, input ready);
    modport sink   (input valid, input status, input granted_slot, input used_count,
                    input highest_used, input lowest_free, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/slot_pool_allocator.sv -----
// Top level of the slot pool allocator: sequencer, pool state and result register.
//
//  Channel   Direction  Payload                                             Handshake
//  i_cmd     in         command, slot                                       valid/ready
//  o_res     out        status, granted_slot, used_count, highest_used,     valid/ready
//                       lowest_free
//
// A transfer that touches the map passes from ST_IDLE through ST_MODIFY to ST_DONE, with
// ST_SCAN visiting further map words as a search needs (WORDS = ceil(SLOTS/16) in all);
// an allocate on a full pool or an out-of-range release skips the map and goes straight
// to ST_DONE. The single read port of the used-map memory and the shared word scanner
// set this order. After reset the map is cleared one word a cycle, with i_cmd not ready.
// A finished result waits in the output register while the next command is taken;
// the sequencer holds a further result until o_res has been drained.
`default_nettype none

module slot_pool_allocator #(
    parameter int SLOTS = spa_pkg::SPA_SLOTS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spa_cmd_if.sink   i_cmd,
    spa_res_if.source o_res
);
    import spa_pkg::*;

    localparam int IDX_W     = $clog2(SLOTS);
    localparam int HINT_W    = $clog2(SLOTS + 1);
    localparam int CNT_W     = HINT_W;
    localparam int TOP_W     = IDX_W + 1;
    localparam int WORDS     = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LAST_BITS = SLOTS - WORD_W * (WORDS - 1);

    localparam logic [WORD_W-1:0]       LAST_MASK = WORD_W'((32'd1 << LAST_BITS) - 32'd1);
    localparam logic [WADDR_W-1:0]      LAST_ADDR = WADDR_W'(WORDS - 1);
    localparam logic [HINT_W-1:0]       HINT_FULL = HINT_W'(SLOTS);
    localparam logic signed [TOP_W-1:0] TOP_NONE  = '1;

    // Bits of a word that stand for real slots.
    function automatic logic [WORD_W-1:0] valid_mask(input logic [WADDR_W-1:0] addr);
        valid_mask = (addr == LAST_ADDR) ? LAST_MASK : '1;
    endfunction

    // Sequencer and pool state.
    t_state                    r_state, n_state;
    logic [WADDR_W-1:0]        r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [TOP_W-1:0]   r_top, n_top;
    logic [HINT_W-1:0]         r_hint, n_hint;
    logic                      r_out_valid, n_out_valid;

    // Working registers of the command in progress.
    logic                      r_cmd, n_cmd;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [WADDR_W-1:0]        r_waddr, n_waddr;
    logic [BIT_W-1:0]          r_bit, n_bit;
    logic [WADDR_W-1:0]        r_eval_addr, n_eval_addr;
    logic [WADDR_W-1:0]        r_scan_addr, n_scan_addr;
    t_status                   r_status, n_status;
    logic [7:0]                r_grant, n_grant;

    // Output register.
    t_status                   r_o_status;
    logic [7:0]                r_o_grant;
    logic [8:0]                r_o_count;
    logic signed [8:0]         r_o_top;
    logic [8:0]                r_o_free;

    // Memory and scanner connections.
    logic                      mem_wr_en;
    logic [WADDR_W-1:0]        mem_wr_addr;
    logic [WORD_W-1:0]         mem_wr_data;
    logic [WADDR_W-1:0]        mem_rd_addr;
    logic [WORD_W-1:0]         mem_rd_data;
    logic [WORD_W-1:0]         sc_cand;
    logic                      sc_found;
    logic [BIT_W-1:0]          sc_pos;

    // Decode helpers.
    logic                      in_acc;
    logic                      is_alloc;
    logic                      acc_full;
    logic                      acc_range;
    logic [IDX_W-1:0]          acc_idx;
    logic [WORD_W-1:0]         bit_oh;
    logic [WORD_W-1:0]         mod_word;
    logic                      bit_used;
    logic                      is_top;
    logic                      mod_end;
    logic                      scan_end;
    logic [WADDR_W-1:0]        sc_base;
    logic [WADDR_W+BIT_W-1:0]  found_full;
    logic                      out_free;

    assign in_acc    = i_cmd.valid && i_cmd.ready;
    assign is_alloc  = (r_cmd == CMD_ALLOC);
    assign acc_full  = (r_hint == HINT_FULL);
    assign acc_range = (int'(i_cmd.slot) < SLOTS);
    assign acc_idx   = (i_cmd.command == CMD_ALLOC) ? IDX_W'(r_hint) : IDX_W'(i_cmd.slot);
    assign bit_oh    = WORD_W'(1) << r_bit;
    assign mod_word  = is_alloc ? (mem_rd_data | bit_oh) : (mem_rd_data & ~bit_oh);
    assign bit_used  = mem_rd_data[r_bit];
    assign is_top    = ($signed({1'b0, r_idx}) == r_top);
    assign mod_end   = is_alloc ? (r_waddr == LAST_ADDR) : (r_waddr == '0);
    assign scan_end  = is_alloc ? (r_eval_addr == LAST_ADDR) : (r_eval_addr == '0);
    assign out_free  = !r_out_valid || o_res.ready;

    // Candidate bits for the shared scanner: free slots upward, used slots downward.
    always_comb begin
        if (r_state == ST_SCAN) begin
            sc_base = r_eval_addr;
            sc_cand = is_alloc ? (~mem_rd_data & valid_mask(r_eval_addr)) : mem_rd_data;
        end else begin
            sc_base = r_waddr;
            sc_cand = is_alloc ? (~mod_word & valid_mask(r_waddr) & ({WORD_W{1'b1}} << r_bit))
                               : (mod_word & (bit_oh - WORD_W'(1)));
        end
    end

    assign found_full = {sc_base, sc_pos};

    spa_word_scan u_scan (
        .i_cand  (sc_cand),
        .i_down  (!is_alloc),
        .o_found (sc_found),
        .o_pos   (sc_pos)
    );

    spa_map_mem #(
        .DEPTH  (WORDS),
        .ADDR_W (WADDR_W)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_cmd.command == CMD_ALLOC) begin
                        n_state = acc_full ? ST_DONE : ST_MODIFY;
                    end else begin
                        n_state = acc_range ? ST_MODIFY : ST_DONE;
                    end
                end
            end
            ST_MODIFY: begin
                if (!is_alloc && (!bit_used || !is_top)) begin
                    n_state = ST_DONE;
                end else if (sc_found || mod_end) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sc_found || scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Datapath updates and memory control.
    always_comb begin
        n_clr_addr  = r_clr_addr;
        n_count     = r_count;
        n_top       = r_top;
        n_hint      = r_hint;
        n_out_valid = r_out_valid && !o_res.ready;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_waddr     = r_waddr;
        n_bit       = r_bit;
        n_eval_addr = r_eval_addr;
        n_scan_addr = r_scan_addr;
        n_status    = r_status;
        n_grant     = r_grant;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_waddr;
        mem_wr_data = mod_word;
        mem_rd_addr = r_scan_addr;
        unique case (r_state)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr_addr;
                mem_wr_data = '0;
                n_clr_addr  = r_clr_addr + WADDR_W'(1);
            end
            ST_IDLE: begin
                // Start the read of the target word as the command is taken.
                mem_rd_addr = WADDR_W'(acc_idx >> BIT_W);
                if (in_acc) begin
                    n_cmd   = i_cmd.command;
                    n_idx   = acc_idx;
                    n_waddr = WADDR_W'(acc_idx >> BIT_W);
                    n_bit   = BIT_W'(acc_idx);
                    n_grant = '0;
                    if (i_cmd.command == CMD_ALLOC) begin
                        n_status = acc_full ? STATUS_FULL : STATUS_OK;
                    end else begin
                        n_status = acc_range ? STATUS_OK : STATUS_BAD;
                    end
                end
            end
            ST_MODIFY: begin
                mem_rd_addr = is_alloc ? (r_waddr + WADDR_W'(1)) : (r_waddr - WADDR_W'(1));
                n_eval_addr = mem_rd_addr;
                n_scan_addr = is_alloc ? (r_waddr + WADDR_W'(2)) : (r_waddr - WADDR_W'(2));
                if (is_alloc) begin
                    // Grant the hinted slot, then look for the next free one above it.
                    mem_wr_en = 1'b1;
                    n_count   = r_count + CNT_W'(1);
                    n_grant   = 8'(r_idx);
                    if ($signed({1'b0, r_idx}) > r_top) begin
                        n_top = $signed({1'b0, r_idx});
                    end
                    if (sc_found) begin
                        n_hint = HINT_W'(found_full);
                    end else if (mod_end) begin
                        n_hint = HINT_FULL;
                    end
                end else if (!bit_used) begin
                    n_status = STATUS_BAD;
                end else begin
                    // Free the slot; a freed top slot starts a downward search.
                    mem_wr_en = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                    if (HINT_W'(r_idx) < r_hint) begin
                        n_hint = HINT_W'(r_idx);
                    end
                    if (is_top) begin
                        if (sc_found) begin
                            n_top = $signed({1'b0, IDX_W'(found_full)});
                        end else if (mod_end) begin
                            n_top = TOP_NONE;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // One word per cycle: evaluate the word read last cycle, fetch the next.
                n_eval_addr = r_scan_addr;
                n_scan_addr = is_alloc ? (r_scan_addr + WADDR_W'(1))
                                       : (r_scan_addr - WADDR_W'(1));
                if (sc_found) begin
                    if (is_alloc) begin
                        n_hint = HINT_W'(found_full);
                    end else begin
                        n_top = $signed({1'b0, IDX_W'(found_full)});
                    end
                end else if (scan_end) begin
                    if (is_alloc) begin
                        n_hint = HINT_FULL;
                    end else begin
                        n_top = TOP_NONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: n_clr_addr = '0;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_top       <= TOP_NONE;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_top       <= n_top;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_waddr     <= n_waddr;
        r_bit       <= n_bit;
        r_eval_addr <= n_eval_addr;
        r_scan_addr <= n_scan_addr;
        r_status    <= n_status;
        r_grant     <= n_grant;
    end

    // Result register, loaded when the finished result moves out of the sequencer.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_o_status <= r_status;
            r_o_grant  <= r_grant;
            r_o_count  <= 9'(r_count);
            r_o_top    <= 9'(r_top);
            r_o_free   <= 9'(r_hint);
        end
    end

    assign i_cmd.ready        = (r_state == ST_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_o_status;
    assign o_res.granted_slot = r_o_grant;
    assign o_res.used_count   = r_o_count;
    assign o_res.highest_used = r_o_top;
    assign o_res.lowest_free  = r_o_free;

    // The free hint and the count never pass the pool size.
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hint <= HINT_FULL) && (r_count <= CNT_W'(SLOTS)))
        else $error("slot count or free hint beyond the pool size");

    // Between commands, an empty pool has no top slot and vice versa.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ((r_count == '0) == (r_top == TOP_NONE)))
        else $error("used count and highest used slot disagree");

    // Between commands, a full pool has no free hint and vice versa.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ((r_count == CNT_W'(SLOTS)) == (r_hint == HINT_FULL)))
        else $error("used count and lowest free slot disagree");

    // A taken command goes straight to the map update or to the result.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_MODIFY || r_state == ST_DONE))
        else $error("command transfer did not start the sequencer");

endmodule

`default_nettype wire

// ----- rtl/core/spa_map_mem.sv -----
// Used-map memory: one write port and one registered read port, one word per address.
`default_nettype none

module spa_map_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [ADDR_W-1:0]          i_wr_addr,
    input  wire logic [spa_pkg::WORD_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0]          i_rd_addr,
    output logic      [spa_pkg::WORD_W-1:0] o_rd_data
);
    import spa_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/core/spa_word_scan.sv -----
// Shared word scanner: finds the lowest or the highest set bit of one map word.
`default_nettype none

module spa_word_scan (
    input  wire logic [spa_pkg::WORD_W-1:0] i_cand,
    input  wire logic                       i_down,
    output logic                            o_found,
    output logic      [spa_pkg::BIT_W-1:0]  o_pos
);
    import spa_pkg::*;

    // Priority encoder; the last match in loop order wins.
    always_comb begin
        o_found = |i_cand;
        o_pos   = '0;
        if (i_down) begin
            for (int i = 0; i < WORD_W; i++) begin
                if (i_cand[i]) begin
                    o_pos = BIT_W'(i);
                end
            end
        end else begin
            for (int i = WORD_W - 1; i >= 0; i--) begin
                if (i_cand[i]) begin
                    o_pos = BIT_W'(i);
                end
            end
        end
    end

endmodule

`default_nettype wire
